/* rtl/trdd_pkg.sv */
// Package for the reading-to-decimal-digits converter.
// It holds the digit type, the conversion constants and the digit-extraction function.
// It has no dependencies.
package trdd_pkg;

  typedef logic [3:0] digit_t;

  // Result of one decimal digit step: the digit and what remains below its place.
  typedef struct packed {
    digit_t      digit;
    logic [16:0] rem;
  } digit_step_t;

  localparam int unsigned MAG_W = 16;
  localparam int unsigned HUND_W = 17;

  // A magnitude of this many sixteenths or more gives more than 999.99 degrees.
  localparam logic [MAG_W-1:0] MAG_SAT = 16'd16000;
  localparam logic [HUND_W-1:0] HUND_MAX = 17'd99999;

  localparam logic [16:0] PLACE_10000 = 17'd10000;
  localparam logic [16:0] PLACE_1000 = 17'd1000;
  localparam logic [16:0] PLACE_100 = 17'd100;
  localparam logic [16:0] PLACE_10 = 17'd10;

  // Finds the decimal digit of r at the given place by comparing against the nine
  // multiples of the place in parallel, and subtracts the chosen multiple.
  // r must be below ten times the place.
  function automatic digit_step_t digit_step(input logic [16:0] r, input logic [16:0] place);
    digit_step_t res;
    logic [20:0] mult;
    logic [20:0] chosen;
    res.digit = '0;
    chosen = '0;
    for (int k = 1; k <= 9; k++) begin
      mult = 21'(k) * {4'd0, place};
      if ({4'd0, r} >= mult) begin
        res.digit = 4'(k);
        chosen = mult;
      end
    end
    res.rem = r - chosen[16:0];
    return res;
  endfunction

endpackage

/* rtl/temp_raw_to_decimal_digits.sv */
// Top level of the reading-to-decimal-digits converter: a six-stage pipeline.
// It depends on trdd_pkg for the digit type, constants and the digit-step function.
//
// The block takes a signed 16-bit temperature reading in sixteenths of a degree, given
// as a low byte and a high byte, and returns the sign, an overflow flag and five decimal
// digits of the magnitude in hundredths of a degree (hundreds, tens and units of degrees,
// then tenths and hundredths, truncated). Magnitudes above 999.99 degrees saturate to all
// nines with overflow set; the sign is still reported. One reading is accepted every
// cycle unless every stage is full and the output stalls. There are six register
// stages, the first of which captures the reading at the accepting edge: sign and
// magnitude, scaling by 25/4 with saturation, and one stage for each of the
// ten-thousands, thousands, hundreds and tens digits. Each stage carries its own valid
// bit and holds only when it is full and the stage after it cannot take its beat, so
// bubbles close up and a waiting result does not block new readings while the pipeline
// has room.
module temp_raw_to_decimal_digits (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          low_byte,
  input  logic [7:0]          high_byte,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                negative,
  output logic                overflow,
  output trdd_pkg::digit_t    digit_hundreds,
  output trdd_pkg::digit_t    digit_tens,
  output trdd_pkg::digit_t    digit_units,
  output trdd_pkg::digit_t    digit_tenths,
  output trdd_pkg::digit_t    digit_hundredths
);

  // Valid bits of the six stages and the load enables that follow from them.
  logic [5:0] v;
  logic [5:0] rdy;

  // Stage 1: sign and magnitude.
  logic                        neg1;
  logic [trdd_pkg::MAG_W-1:0]  mag1;
  // Stage 2: hundredths of a degree, saturated.
  logic                        neg2, ovf2;
  logic [trdd_pkg::HUND_W-1:0] h2;
  // Stage 3: ten-thousands digit taken off.
  logic                        neg3, ovf3;
  trdd_pkg::digit_t            d4_3;
  logic [13:0]                 r3;
  // Stage 4: thousands digit taken off.
  logic                        neg4, ovf4;
  trdd_pkg::digit_t            d4_4, d3_4;
  logic [9:0]                  r4;
  // Stage 5: hundreds digit taken off.
  logic                        neg5, ovf5;
  trdd_pkg::digit_t            d4_5, d3_5, d2_5;
  logic [6:0]                  r5;
  // Stage 6: tens digit taken off; the remainder is the hundredths digit.
  logic                        neg6, ovf6;
  trdd_pkg::digit_t            d4_6, d3_6, d2_6, d1_6, d0_6;

  logic [15:0]                 raw;
  logic [16:0]                 neg_mag;
  logic [trdd_pkg::MAG_W-1:0]  mag_next;
  logic [20:0]                 prod;
  trdd_pkg::digit_step_t       step3, step4, step5, step6;

  // A stage loads when it is empty or its content moves on in the same cycle.
  assign rdy[5] = !v[5] || out_ready;
  assign rdy[4] = !v[4] || rdy[5];
  assign rdy[3] = !v[3] || rdy[4];
  assign rdy[2] = !v[2] || rdy[3];
  assign rdy[1] = !v[1] || rdy[2];
  assign rdy[0] = !v[0] || rdy[1];
  assign in_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) begin
        v[0] <= in_valid;
      end
      for (int i = 1; i < 6; i++) begin
        if (rdy[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // The magnitude of a negative reading is its negation over 17 bits, so the most
  // negative code still gives a positive magnitude of 32768.
  always_comb begin
    raw = {high_byte, low_byte};
    neg_mag = 17'h10000 - {1'b0, raw};
    mag_next = raw[15] ? neg_mag[15:0] : raw;
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      neg1 <= raw[15];
      mag1 <= mag_next;
    end
  end

  // Hundredths are the magnitude times 25, divided by 4 with truncation.
  assign prod = {5'd0, mag1} * 21'd25;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      neg2 <= neg1;
      ovf2 <= (mag1 >= trdd_pkg::MAG_SAT);
      h2 <= (mag1 >= trdd_pkg::MAG_SAT) ? trdd_pkg::HUND_MAX : prod[18:2];
    end
  end

  assign step3 = trdd_pkg::digit_step(h2, trdd_pkg::PLACE_10000);
  assign step4 = trdd_pkg::digit_step({3'd0, r3}, trdd_pkg::PLACE_1000);
  assign step5 = trdd_pkg::digit_step({7'd0, r4}, trdd_pkg::PLACE_100);
  assign step6 = trdd_pkg::digit_step({10'd0, r5}, trdd_pkg::PLACE_10);

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      neg3 <= neg2;
      ovf3 <= ovf2;
      d4_3 <= step3.digit;
      r3 <= step3.rem[13:0];
    end
    if (rdy[3]) begin
      neg4 <= neg3;
      ovf4 <= ovf3;
      d4_4 <= d4_3;
      d3_4 <= step4.digit;
      r4 <= step4.rem[9:0];
    end
    if (rdy[4]) begin
      neg5 <= neg4;
      ovf5 <= ovf4;
      d4_5 <= d4_4;
      d3_5 <= d3_4;
      d2_5 <= step5.digit;
      r5 <= step5.rem[6:0];
    end
    if (rdy[5]) begin
      neg6 <= neg5;
      ovf6 <= ovf5;
      d4_6 <= d4_5;
      d3_6 <= d3_5;
      d2_6 <= d2_5;
      d1_6 <= step6.digit;
      d0_6 <= step6.rem[3:0];
    end
  end

  assign out_valid = v[5];
  assign negative = neg6;
  assign overflow = ovf6;
  assign digit_hundreds = d4_6;
  assign digit_tens = d3_6;
  assign digit_units = d2_6;
  assign digit_tenths = d1_6;
  assign digit_hundredths = d0_6;

`ifndef NO_ASSERTIONS
  // Every digit of a delivered result is a decimal digit.
  a_digits_decimal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (digit_hundreds <= 4'd9) && (digit_tens <= 4'd9) && (digit_units <= 4'd9)
      && (digit_tenths <= 4'd9) && (digit_hundredths <= 4'd9))
    else $error("result digit out of decimal range");

  // A saturated result reads all nines.
  a_overflow_nines: assert property (@(posedge clk) disable iff (rst)
    (out_valid && overflow) |-> (digit_hundreds == 4'd9) && (digit_tens == 4'd9)
      && (digit_units == 4'd9) && (digit_tenths == 4'd9) && (digit_hundredths == 4'd9))
    else $error("overflow result is not all nines");

  // Input back-pressure only arises when every stage is full and the output stalls.
  a_full_before_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (&v) && !out_ready)
    else $error("input stalled while the pipeline has room");

  // A stage that is full and held keeps its valid bit.
  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (v[2] && !rdy[3]) |=> v[2])
    else $error("held stage lost its beat");
`endif

endmodule

/* tb/tb_temp_raw_to_decimal_digits.sv */
// Testbench for temp_raw_to_decimal_digits: signed sixteenth-degree readings in, decimal digits out.
// It depends on trdd_pkg for the digit type and on the converter RTL; it needs no other file.
`timescale 1ns / 1ps

module tb_temp_raw_to_decimal_digits;

  // One reading as the two input bytes carry it.
  typedef struct packed {
    logic [7:0] low_byte;
    logic [7:0] high_byte;
  } reading_t;

  // One converted result, in the order of the output ports.
  typedef struct packed {
    logic             negative;
    logic             overflow;
    trdd_pkg::digit_t digit_hundreds;
    trdd_pkg::digit_t digit_tens;
    trdd_pkg::digit_t digit_units;
    trdd_pkg::digit_t digit_tenths;
    trdd_pkg::digit_t digit_hundredths;
  } digits_t;

  localparam int unsigned RANDOM_READINGS = 1200;
  // Hundredths of a degree above which the digits saturate.
  localparam int unsigned HUNDREDTHS_LIMIT = 99999;
  // The pipeline is six stages deep; the drain wait gives it ample margin.
  localparam int unsigned DRAIN_CYCLES = 20;
  // Both sides run without gaps from this many beats on until STEADY_LAST have gone by.
  localparam int unsigned STEADY_FIRST = 400;
  localparam int unsigned STEADY_LAST = 700;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic       [7:0] low_byte = 8'd0;
  logic       [7:0] high_byte = 8'd0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             negative;
  logic             overflow;
  trdd_pkg::digit_t digit_hundreds;
  trdd_pkg::digit_t digit_tens;
  trdd_pkg::digit_t digit_units;
  trdd_pkg::digit_t digit_tenths;
  trdd_pkg::digit_t digit_hundredths;

  reading_t    pending_readings[$];
  digits_t     expected_digits[$];
  int unsigned readings_sent = 0;
  int unsigned results_seen = 0;
  int unsigned negatives_seen = 0;
  int unsigned overflows_seen = 0;
  int unsigned mismatches = 0;

  temp_raw_to_decimal_digits DUT (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .low_byte         (low_byte),
    .high_byte        (high_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .negative         (negative),
    .overflow         (overflow),
    .digit_hundreds   (digit_hundreds),
    .digit_tens       (digit_tens),
    .digit_units      (digit_units),
    .digit_tenths     (digit_tenths),
    .digit_hundredths (digit_hundredths)
  );

  always #5 clk = ~clk;

  // Converts one reading the way the block should: take the sign from bit 15, negate over
  // 17 bits so that the most negative code gives 32768, scale by 25/4 with truncation,
  // then saturate to 999.99 degrees and split into decimal places.
  function automatic digits_t reading_to_digits(input logic [7:0] lo, input logic [7:0] hi);
    logic [15:0] raw;
    int unsigned magnitude;
    int unsigned hundredths;
    digits_t     res;
    raw = {hi, lo};
    res.negative = raw[15];
    magnitude = raw[15] ? (32'h10000 - int'(raw)) : int'(raw);
    hundredths = (magnitude * 25) / 4;
    res.overflow = hundredths > HUNDREDTHS_LIMIT;
    if (res.overflow) begin
      hundredths = HUNDREDTHS_LIMIT;
    end
    res.digit_hundreds = trdd_pkg::digit_t'(hundredths / 10000);
    res.digit_tens = trdd_pkg::digit_t'((hundredths / 1000) % 10);
    res.digit_units = trdd_pkg::digit_t'((hundredths / 100) % 10);
    res.digit_tenths = trdd_pkg::digit_t'((hundredths / 10) % 10);
    res.digit_hundredths = trdd_pkg::digit_t'(hundredths % 10);
    return res;
  endfunction

  task automatic add_reading(input logic [15:0] value);
    pending_readings.push_back('{low_byte: value[7:0], high_byte: value[15:8]});
  endtask

  // Input side. A beat leaves the port when valid and ready meet at an edge; its expected
  // digits are queued at that same edge. The next beat is offered right away unless this
  // cycle is picked as a gap. While a beat waits for ready, valid and the bytes stay put.
  always @(posedge clk) begin : drive_readings
    reading_t beat;
    bit       gap;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        expected_digits.push_back(reading_to_digits(low_byte, high_byte));
        readings_sent++;
      end
      gap = ($urandom_range(99) < 13) &&
            !(readings_sent >= STEADY_FIRST && readings_sent < STEADY_LAST);
      if (pending_readings.size() > 0 && !gap) begin
        beat = pending_readings.pop_front();
        low_byte <= beat.low_byte;
        high_byte <= beat.high_byte;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output side. Every accepted result is held against the oldest expectation; a result
  // with nothing waiting is an error too. Ready drops at random, except in the steady
  // window, so that back pressure lands on every stage of the pipeline.
  always @(posedge clk) begin : check_digits
    digits_t got;
    digits_t want;
    bit      stall;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got = '{negative, overflow, digit_hundreds, digit_tens, digit_units,
                digit_tenths, digit_hundredths};
        results_seen++;
        if (got.negative) negatives_seen++;
        if (got.overflow) overflows_seen++;
        if (expected_digits.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result with no reading waiting: %p", $time, got);
          end
        end else begin
          want = expected_digits.pop_front();
          if (got.negative !== want.negative || got.overflow !== want.overflow ||
              got.digit_hundreds !== want.digit_hundreds ||
              got.digit_tens !== want.digit_tens ||
              got.digit_units !== want.digit_units ||
              got.digit_tenths !== want.digit_tenths ||
              got.digit_hundredths !== want.digit_hundredths) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: result %0d wrong: expected %p, got %p",
                       $time, results_seen, want, got);
            end
          end
        end
      end
      stall = ($urandom_range(99) < 13) &&
              !(results_seen >= STEADY_FIRST && results_seen < STEADY_LAST);
      out_ready <= !stall;
    end
  end

  // Stimulus and end of run.
  initial begin : run_readings
    int unsigned pick;
    int unsigned magnitude;
    int unsigned total_readings;
    logic [15:0] value;

    // Directed readings: zero, the smallest steps either way, the full-scale codes, the
    // saturation edge on both signs, whole degrees and alternating bit patterns.
    add_reading(16'h0000);
    add_reading(16'h0001);
    add_reading(16'h0002);
    add_reading(16'h0003);
    add_reading(16'hFFFF);  // minus one sixteenth: sign kept, digits 0.06
    add_reading(16'hFFF0);  // minus one degree
    add_reading(16'h0010);
    add_reading(16'h0190);
    add_reading(16'h7FFF);
    add_reading(16'h8000);  // most negative code, magnitude 32768
    add_reading(16'h8001);
    add_reading(16'd15999); // largest magnitude that still fits in 999.99
    add_reading(16'd16000); // first magnitude that saturates
    add_reading(-16'sd15999);
    add_reading(-16'sd16000);
    add_reading(16'h00FF);
    add_reading(16'hFF00);
    add_reading(16'h5555);
    add_reading(16'hAAAA);
    add_reading(16'h00AA);

    // Random readings: most in the range that gives real digits, some packed around the
    // saturation edge, the rest any 16-bit code at all.
    for (int i = 0; i < RANDOM_READINGS; i++) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        magnitude = $urandom_range(15999);
      end else if (pick < 80) begin
        magnitude = $urandom_range(16008, 15992);
      end else begin
        magnitude = $urandom;
      end
      value = magnitude[15:0];
      if (pick < 80 && $urandom_range(1) == 1) begin
        value = -value;
      end
      add_reading(value);
    end
    total_readings = pending_readings.size();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Wait until every reading has been accepted, then for the results to drain.
    wait (readings_sent == total_readings);
    wait (expected_digits.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_digits.size() != 0) begin
      mismatches++;
      $display("%0d expected results never arrived", expected_digits.size());
    end
    $display("Converted %0d readings into %0d results; %0d negative, %0d saturated.",
             readings_sent, results_seen, negatives_seen, overflows_seen);
    $display("Mismatches: %0d.", mismatches);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Guard against a hung handshake: far beyond the slowest correct run.
  initial begin : watchdog
    #2000000;
    $display("Run timed out with %0d results still expected.", expected_digits.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
